[rtl/set_assoc_lru_cache_model_defines.svh]
// assertion macros shared by the checker of the cache model
// no dependencies
`ifndef SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH

// plain property check, disabled while reset is asserted
`define SALC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define SALC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/salc_pkg.sv]
// shared codes and types of the set-associative cache model
// no dependencies
`timescale 1ns / 1ps
package salc_pkg;
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_STORE  = 2'd1;
	localparam logic [1:0] OP_MODIFY = 2'd2;
	localparam logic [1:0] OP_INSTR  = 2'd3;

	localparam logic [1:0] REG_SET_BITS = 2'd0;
	localparam logic [1:0] REG_WAYS     = 2'd1;
	localparam logic [1:0] REG_OFFSET   = 2'd2;

	typedef struct packed {
		logic [2:0] set_index_bits;
		logic [3:0] ways_in_use;
		logic [4:0] block_offset_bits;
	} cfg_t;

	typedef struct packed {
		logic        hit;
		logic        eviction;
		logic        last;
		logic [31:0] hits_total;
		logic [31:0] misses_total;
		logic [31:0] evictions_total;
	} result_t;
endpackage

[rtl/salc_front.sv]
// front end: accepts trace requests, splits set and tag, expands modify
// depends on salc_pkg
`timescale 1ns / 1ps
module salc_front import salc_pkg::*; #(
	parameter int ADDR_WIDTH   = 32,
	parameter int MAX_SET_BITS = 6,
	parameter int SET_W        = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                op,
	input  logic [ADDR_WIDTH-1:0]     addr,
	output logic                      q_push,
	output logic [ADDR_WIDTH+SET_W:0] q_data,
	input  logic                      q_full
);
	localparam int XW = (ADDR_WIDTH > SET_W) ? ADDR_WIDTH : SET_W;

	logic                  hold_q;
	logic                  twice_q;
	logic [SET_W-1:0]      set_s1;
	logic [ADDR_WIDTH-1:0] tag_s1;
	logic [3:0]            s_eff;
	logic [5:0]            tag_sh;
	logic [XW-1:0]         shifted;
	logic [XW-1:0]         set_x;
	logic                  accept;

	always_comb begin
		s_eff = ({1'b0, cfg.set_index_bits} > 4'(MAX_SET_BITS)) ?
			4'(MAX_SET_BITS) : {1'b0, cfg.set_index_bits};
		shifted = XW'(addr) >> cfg.block_offset_bits;
		set_x = shifted & ~({XW{1'b1}} << s_eff);
		tag_sh = 6'(s_eff) + 6'(cfg.block_offset_bits);
	end

	assign in_stall = hold_q;
	assign accept = in_valid && !hold_q;
	assign q_push = hold_q && !q_full;
	// layout: last, set, tag
	assign q_data = {!twice_q, set_s1, tag_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			twice_q <= 1'b0;
		end else if (accept && op != OP_INSTR) begin
			hold_q <= 1'b1;
			twice_q <= (op == OP_MODIFY);
		end else if (q_push) begin
			if (twice_q) begin
				twice_q <= 1'b0;
			end else begin
				hold_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= set_x[SET_W-1:0];
			tag_s1 <= addr >> tag_sh;
		end
	end
endmodule

[rtl/salc_queue.sv]
// two-entry queue of accesses between front and back end
// no dependencies
`timescale 1ns / 1ps
module salc_queue #(
	parameter int DATA_W = 39
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output logic [DATA_W-1:0] pop_data
);
	logic [DATA_W-1:0] data_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data = data_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) data_q[wr_ptr_q] <= push_data;
	end
endmodule

[rtl/salc_back.sv]
// back end: set lookup, lru victim search, line update and result register
// depends on salc_pkg
`timescale 1ns / 1ps
module salc_back import salc_pkg::*; #(
	parameter int ADDR_WIDTH   = 32,
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int SET_W        = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [3:0]                ways_in_use,
	input  logic                      q_valid,
	input  logic [ADDR_WIDTH+SET_W:0] q_data,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output result_t                   res
);
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W = $clog2(MAX_WAYS + 1);
	localparam int EW = 1 + ADDR_WIDTH + 64;

	typedef enum logic [1:0] {S_IDLE, S_LOOK, S_LRU, S_WB} state_t;

	state_t                state_q;
	logic [SET_W-1:0]      set_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic                  last_q;
	logic [63:0]           clk_q;
	logic [31:0]           hit_cnt_q;
	logic [31:0]           miss_cnt_q;
	logic [31:0]           ev_cnt_q;
	logic [WAY_W-1:0]      way_q;
	logic [WAY_W-1:0]      idx_q;
	logic                  hit_q;
	logic                  ev_q;
	logic [NUM_SETS-1:0]   row_valid_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic                  rd_valid [MAX_WAYS];
	logic [ADDR_WIDTH-1:0] rd_tag   [MAX_WAYS];
	logic [63:0]           rd_stamp [MAX_WAYS];
	logic                  we       [MAX_WAYS];
	logic [EW-1:0]         wdata    [MAX_WAYS];

	logic [SET_W-1:0]      q_set;
	logic [5:0]            wx;
	logic [CNT_W-1:0]      e_eff;
	logic                  rv;
	logic                  any_hit;
	logic                  any_empty;
	logic [WAY_W-1:0]      hit_way;
	logic [WAY_W-1:0]      empty_way;
	logic                  wb_go;
	logic [31:0]           hit_nx;
	logic [31:0]           miss_nx;
	logic [31:0]           ev_nx;

	assign q_set = q_data[ADDR_WIDTH +: SET_W];
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign rv = row_valid_q[set_q];
	assign wb_go = (state_q == S_WB) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res = out_q;

	always_comb begin
		wx = {2'b00, ways_in_use};
		if (wx == 6'd0) begin
			e_eff = CNT_W'(1);
		end else if (wx > 6'(MAX_WAYS)) begin
			e_eff = CNT_W'(MAX_WAYS);
		end else begin
			e_eff = CNT_W'(wx);
		end
	end

	// first matching way and first free way among the ways in use
	always_comb begin
		any_hit = 1'b0;
		any_empty = 1'b0;
		hit_way = '0;
		empty_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (CNT_W'(w) < e_eff) begin
				if (rv && rd_valid[w] && rd_tag[w] == tag_q) begin
					any_hit = 1'b1;
					hit_way = WAY_W'(w);
				end
				if (!(rv && rd_valid[w])) begin
					any_empty = 1'b1;
					empty_way = WAY_W'(w);
				end
			end
		end
	end

	// a row touched for the first time clears the stale valid bits of its other ways
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			we[w] = wb_go && (WAY_W'(w) == way_q || !rv);
			wdata[w] = (WAY_W'(w) == way_q) ? {1'b1, tag_q, clk_q} : '0;
		end
	end

	for (genvar g = 0; g < MAX_WAYS; g++) begin : g_way
		logic [EW-1:0] mem [NUM_SETS];
		logic [EW-1:0] rd_q;
		always_ff @(posedge clk) begin
			if (we[g]) mem[set_q] <= wdata[g];
			if (q_pop) rd_q <= mem[q_set];
		end
		assign rd_valid[g] = rd_q[EW-1];
		assign rd_tag[g] = rd_q[64 +: ADDR_WIDTH];
		assign rd_stamp[g] = rd_q[63:0];
	end

	assign hit_nx = hit_cnt_q + 32'(hit_q);
	assign miss_nx = miss_cnt_q + 32'(!hit_q);
	assign ev_nx = ev_cnt_q + 32'(ev_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clk_q <= '0;
			hit_cnt_q <= '0;
			miss_cnt_q <= '0;
			ev_cnt_q <= '0;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) state_q <= S_LOOK;
				end
				S_LOOK: begin
					clk_q <= clk_q + 64'd1;
					if (any_hit) begin
						state_q <= S_WB;
					end else if (any_empty) begin
						state_q <= S_WB;
					end else if (e_eff == CNT_W'(1)) begin
						state_q <= S_WB;
					end else begin
						state_q <= S_LRU;
					end
				end
				S_LRU: begin
					if (CNT_W'(idx_q) == e_eff - CNT_W'(1)) state_q <= S_WB;
				end
				S_WB: begin
					if (wb_go) begin
						row_valid_q[set_q] <= 1'b1;
						hit_cnt_q <= hit_nx;
						miss_cnt_q <= miss_nx;
						ev_cnt_q <= ev_nx;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					last_q <= q_data[ADDR_WIDTH+SET_W];
					set_q <= q_set;
					tag_q <= q_data[ADDR_WIDTH-1:0];
				end
			end
			S_LOOK: begin
				hit_q <= any_hit;
				ev_q <= !any_hit && !any_empty;
				idx_q <= WAY_W'(1);
				if (any_hit) begin
					way_q <= hit_way;
				end else if (any_empty) begin
					way_q <= empty_way;
				end else begin
					way_q <= '0;
				end
			end
			S_LRU: begin
				// strict compare keeps the lowest way on a tie
				if (rd_stamp[idx_q] < rd_stamp[way_q]) way_q <= idx_q;
				idx_q <= idx_q + WAY_W'(1);
			end
			S_WB: begin
				if (wb_go) begin
					out_q.hit <= hit_q;
					out_q.eviction <= ev_q;
					out_q.last <= last_q;
					out_q.hits_total <= hit_nx;
					out_q.misses_total <= miss_nx;
					out_q.evictions_total <= ev_nx;
				end
			end
			default: ;
		endcase
	end
endmodule

[rtl/set_assoc_lru_cache_model.sv]
// Set-associative cache model with LRU replacement.
// Input channel (in_valid/in_stall, op, addr) takes one trace request per accept;
// load and store make one access, modify makes two (load then store), an
// instruction fetch is taken and makes no result.
// Output channel (out_valid/out_stall) gives one result per access: hit,
// eviction, last (final result of the request) and the running totals.
// The front end splits set and tag and pushes accesses into a two-entry
// queue; the back end works one access at a time.
// In the back end an access goes through set read, compare and write back, with
// a victim search before write back when a full set misses and more than one
// way is in use.
// Configuration goes through the APB port at byte addresses 0, 4 and 8.
// Reset invalidates all lines through the per-set valid bits, so lines need no
// clearing pass; it clears the access clock, the totals and the registers (set bits 0, ways 1, offset 0).
// A stalled result holds in the output register; the back end waits on it and
// the queue and front end fill and then stall the input.
// depends on salc_pkg, salc_front, salc_queue, salc_back
`timescale 1ns / 1ps
module set_assoc_lru_cache_model import salc_pkg::*; #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            op,
	input  logic [ADDR_WIDTH-1:0] addr,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic                  eviction,
	output logic                  last,
	output logic [31:0]           hits_total,
	output logic [31:0]           misses_total,
	output logic [31:0]           evictions_total
);
	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int DW = ADDR_WIDTH + SET_W + 1;

	cfg_t          cfg_q;
	logic          q_push;
	logic [DW-1:0] q_wdata;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	logic [DW-1:0] q_rdata;
	result_t       res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_index_bits <= 3'd0;
			cfg_q.ways_in_use <= 4'd1;
			cfg_q.block_offset_bits <= 5'd0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_SET_BITS: cfg_q.set_index_bits <= pwdata[2:0];
				REG_WAYS:     cfg_q.ways_in_use <= pwdata[3:0];
				REG_OFFSET:   cfg_q.block_offset_bits <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SET_BITS: prdata = {29'd0, cfg_q.set_index_bits};
			REG_WAYS:     prdata = {28'd0, cfg_q.ways_in_use};
			REG_OFFSET:   prdata = {27'd0, cfg_q.block_offset_bits};
			default:      prdata = 32'd0;
		endcase
	end

	salc_front #(
		.ADDR_WIDTH(ADDR_WIDTH),
		.MAX_SET_BITS(MAX_SET_BITS),
		.SET_W(SET_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.addr(addr),
		.q_push(q_push),
		.q_data(q_wdata),
		.q_full(q_full)
	);

	salc_queue #(.DATA_W(DW)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.pop_valid(q_valid),
		.pop_data(q_rdata)
	);

	salc_back #(
		.ADDR_WIDTH(ADDR_WIDTH),
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS(MAX_WAYS),
		.SET_W(SET_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ways_in_use(cfg_q.ways_in_use),
		.q_valid(q_valid),
		.q_data(q_rdata),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res(res)
	);

	assign hit = res.hit;
	assign eviction = res.eviction;
	assign last = res.last;
	assign hits_total = res.hits_total;
	assign misses_total = res.misses_total;
	assign evictions_total = res.evictions_total;
endmodule

[rtl/salc_checker.sv]
// port-level checks of the cache model and their bind to the top level
// depends on set_assoc_lru_cache_model_defines.svh
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_model_defines.svh"
module salc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic        eviction,
	input logic        last,
	input logic [31:0] hits_total,
	input logic [31:0] misses_total,
	input logic [31:0] evictions_total
);
	// a stalled result stays put
	`SALC_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(hit) && $stable(eviction) && $stable(last) && $stable(hits_total) && $stable(misses_total) && $stable(evictions_total), "stalled result changed")
	// only a miss can evict
	`SALC_ASSERT(a_hit_no_evict, clk, arst_n, out_valid |-> !(hit && eviction), "hit with eviction")
	// config port never waits
	`SALC_ASSERT_ALWAYS(a_pready, clk, pready, "pready low")
endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pready(pready),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.hit(hit),
	.eviction(eviction),
	.last(last),
	.hits_total(hits_total),
	.misses_total(misses_total),
	.evictions_total(evictions_total)
);
